FILE: rtl/cvl_pkg.sv
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared types, codes and defaults of the compacting value list.
// ----------------------------------------------------------------------------
package cvl_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int ENTRY_WIDTH_DEFAULT = 32;

  // fixed request/result field widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_VAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_IDX = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } cvl_state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic wr;        // write key at pos
    logic shift;     // cells at or above pos take their upper neighbor
    logic get_mode;  // scan selects by position instead of by value
  } cvl_ctl_t;

endpackage

FILE: rtl/cvl_cell.sv
// ----------------------------------------------------------------------------
// cvl_cell
// One list slot: holds an entry, shifts down on removal, and forwards the
// first-hit token of the search ripple to the next slot.
// ----------------------------------------------------------------------------
module cvl_cell #(
  parameter int DEPTH       = cvl_pkg::DEPTH_DEFAULT,
  parameter int ENTRY_WIDTH = cvl_pkg::ENTRY_WIDTH_DEFAULT,
  parameter int CELL_INDEX  = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cvl_pkg::cvl_ctl_t                   ctl,
  input  logic [ENTRY_WIDTH-1:0]              key,
  input  logic [$clog2(DEPTH)-1:0]            pos,
  input  logic [$clog2(DEPTH+1)-1:0]          count,
  input  logic [ENTRY_WIDTH-1:0]              upper_entry,
  output logic [ENTRY_WIDTH-1:0]              entry,
  input  logic                                tok_in_hit,
  input  logic [$clog2(DEPTH)-1:0]            tok_in_pos,
  input  logic [ENTRY_WIDTH-1:0]              tok_in_data,
  output logic                                tok_hit,
  output logic [$clog2(DEPTH)-1:0]            tok_pos,
  output logic [ENTRY_WIDTH-1:0]              tok_data
);
  import cvl_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [IW-1:0] MY_POS   = IW'(CELL_INDEX);
  localparam logic [CW-1:0] MY_COUNT = CW'(CELL_INDEX);

  logic in_use;
  logic sel;

  assign in_use = MY_COUNT < count;
  assign sel    = in_use && (ctl.get_mode ? (MY_POS == pos) : (entry == key));

  always_ff @(posedge clk) begin
    if (ctl.wr && (MY_POS == pos)) begin
      entry <= key;
    end else if (ctl.shift && (MY_POS >= pos)) begin
      entry <= upper_entry;
    end
  end

  // first hit wins: once a lower cell has hit, pass its token along
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_hit <= 1'b0;
    end else begin
      tok_hit <= tok_in_hit || sel;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_hit) begin
      tok_pos  <= tok_in_pos;
      tok_data <= tok_in_data;
    end else begin
      tok_pos  <= MY_POS;
      tok_data <= entry;
    end
  end

endmodule

FILE: rtl/compacting_value_list_unit.sv
// ----------------------------------------------------------------------------
// compacting_value_list_unit
// Packed, order-keeping list of up to DEPTH values built as a row of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells; cell k holds entry k and the list
// is always packed from cell 0 up to count-1. Append, remove by index and
// any request rejected up front (full list, index out of range, unused
// code) finish in the cycle they are accepted. Get, find and remove by
// value launch a token that ripples along the cell row one cell per clock;
// the first matching cell claims it and carries its position and entry to
// the end of the row. These requests return their result once the scan
// counter shows the token has passed the whole row and the output register
// is free. Removal moves every cell at or above the removed position down
// by one at once. One request is in work at a time; a result waits in an
// output register and the next request is taken in the cycle that register
// is emptied. No clearing pass after reset: cells above count are never read.
module compacting_value_list_unit #(
  parameter int DEPTH       = cvl_pkg::DEPTH_DEFAULT,
  parameter int ENTRY_WIDTH = cvl_pkg::ENTRY_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value_in, [37:32] index_in, zero pad
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] value_out, [37:32] index_out,
                                 // [44:38] count_out, zero pad
  output logic [1:0]  m_tuser    // [1:0] status
);
  import cvl_pkg::*;

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH+1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cvl_state_t           state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        scan_cnt;
  logic [CMD_W-1:0]     op_cmd;
  logic [ENTRY_WIDTH-1:0] op_key;
  logic [IW-1:0]        op_idx;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [VALUE_W-1:0]   out_value;
  logic [INDEX_W-1:0]   out_index;
  logic [COUNT_W-1:0]   out_count;

  // request fields
  logic [CMD_W-1:0]       in_cmd;
  logic [ENTRY_WIDTH-1:0] in_val;
  logic [INDEX_W-1:0]     in_idx;
  logic                   accept;
  logic                   out_free;
  logic                   idx_ok;
  logic                   scan_done;

  // sequencer outputs
  cvl_ctl_t               ctl;
  logic [IW-1:0]          pos_bus;
  logic [ENTRY_WIDTH-1:0] key_bus;
  logic                   load;
  logic [STATUS_W-1:0]    res_status;
  logic [VALUE_W-1:0]     res_value;
  logic [INDEX_W-1:0]     res_index;

  // cell row; token slot 0 is the empty token entering the row
  logic [ENTRY_WIDTH-1:0] entry_row [DEPTH];
  logic                   tok_hit   [DEPTH+1];
  logic [IW-1:0]          tok_pos   [DEPTH+1];
  logic [ENTRY_WIDTH-1:0] tok_data  [DEPTH+1];

  assign in_cmd = s_tuser;
  assign in_val = ENTRY_WIDTH'(s_tdata[31:0]);
  assign in_idx = s_tdata[37:32];

  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign idx_ok    = CMPW'(in_idx) < CMPW'(count);
  // last cell's token has seen the whole row once the scan counter reaches the row length
  assign scan_done = (state == ST_SCAN) && (scan_cnt == FULL_COUNT) && out_free;

  assign key_bus = (state == ST_IDLE) ? in_val : op_key;

  always_comb begin
    state_next   = state;
    count_next   = count;
    ctl          = '0;
    ctl.get_mode = (state == ST_SCAN) && (op_cmd == CMD_GET);
    pos_bus      = op_idx;
    load         = 1'b0;
    res_status   = STAT_OK;
    res_value    = '0;
    res_index    = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_APPEND: begin
              load = 1'b1;
              if (count == FULL_COUNT) begin
                res_status = STAT_FULL;
              end else begin
                ctl.wr     = 1'b1;
                pos_bus    = IW'(count);
                count_next = count + CW'(1);
              end
            end
            CMD_GET: begin
              if (!idx_ok) begin
                load       = 1'b1;
                res_status = STAT_RANGE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            CMD_FIND, CMD_REM_VAL: begin
              state_next = ST_SCAN;
            end
            CMD_REM_IDX: begin
              load = 1'b1;
              if (!idx_ok) begin
                res_status = STAT_RANGE;
              end else begin
                ctl.shift  = 1'b1;
                pos_bus    = IW'(in_idx);
                count_next = count - CW'(1);
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_IDLE;
          load       = 1'b1;
          case (op_cmd)
            CMD_GET: begin
              res_value = VALUE_W'(tok_data[DEPTH]);
            end
            CMD_FIND: begin
              if (tok_hit[DEPTH]) begin
                res_index = INDEX_W'(tok_pos[DEPTH]);
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            CMD_REM_VAL: begin
              if (tok_hit[DEPTH]) begin
                res_index  = INDEX_W'(tok_pos[DEPTH]);
                ctl.shift  = 1'b1;
                pos_bus    = tok_pos[DEPTH];
                count_next = count - CW'(1);
              end else begin
                res_status = STAT_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (accept) begin
      scan_cnt <= '0;
    end else if ((state == ST_SCAN) && (scan_cnt != FULL_COUNT)) begin
      scan_cnt <= scan_cnt + CW'(1);
    end
  end

  // operands held for the length of a scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd <= in_cmd;
      op_key <= in_val;
      op_idx <= IW'(in_idx);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_index  <= res_index;
      out_count  <= COUNT_W'(count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {3'b000, out_count, out_index, out_value};

  // cell row
  assign tok_hit[0]  = 1'b0;
  assign tok_pos[0]  = '0;
  assign tok_data[0] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] upper;
    if (k == DEPTH - 1) begin : g_top
      assign upper = entry_row[k];
    end else begin : g_mid
      assign upper = entry_row[k+1];
    end

    cvl_cell #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key         (key_bus),
      .pos         (pos_bus),
      .count       (count),
      .upper_entry (upper),
      .entry       (entry_row[k]),
      .tok_in_hit  (tok_hit[k]),
      .tok_in_pos  (tok_pos[k]),
      .tok_in_data (tok_data[k]),
      .tok_hit     (tok_hit[k+1]),
      .tok_pos     (tok_pos[k+1]),
      .tok_data    (tok_data[k+1])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= FULL_COUNT))
    else $error("scan counter past row length");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_cmd == CMD_APPEND) && (count != FULL_COUNT))
      |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow the list");

  a_remidx_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_cmd == CMD_REM_IDX) && idx_ok)
      |=> (count == $past(count) - CW'(1)))
    else $error("remove by index did not shrink the list");

endmodule
